// ===== src/rlkd_pkg.sv =====
// shared types and constants for the resistor ladder key debouncer
package rlkd_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int STAMP_W    = 32;
   localparam int LIMIT_W    = 11;
   localparam int SETTLE_W   = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [2:0] {
      KEY_NONE   = 3'd0,
      KEY_RIGHT  = 3'd1,
      KEY_UP     = 3'd2,
      KEY_DOWN   = 3'd3,
      KEY_LEFT   = 3'd4,
      KEY_SELECT = 3'd5
   } key_type;

   typedef enum logic {
      OP_POLL  = 1'b0,
      OP_CLEAR = 1'b1
   } opcode_type;

   typedef logic [CSR_ADDR_W-1:0] csr_index_type;

   localparam csr_index_type CSR_RIGHT_LIMIT  = 3'd0;
   localparam csr_index_type CSR_UP_LIMIT     = 3'd1;
   localparam csr_index_type CSR_DOWN_LIMIT   = 3'd2;
   localparam csr_index_type CSR_LEFT_LIMIT   = 3'd3;
   localparam csr_index_type CSR_SELECT_LIMIT = 3'd4;
   localparam csr_index_type CSR_SETTLE_MS    = 3'd5;

   localparam logic [LIMIT_W-1:0]  RIGHT_LIMIT_RST  = 11'd50;
   localparam logic [LIMIT_W-1:0]  UP_LIMIT_RST     = 11'd200;
   localparam logic [LIMIT_W-1:0]  DOWN_LIMIT_RST   = 11'd400;
   localparam logic [LIMIT_W-1:0]  LEFT_LIMIT_RST   = 11'd600;
   localparam logic [LIMIT_W-1:0]  SELECT_LIMIT_RST = 11'd800;
   localparam logic [SETTLE_W-1:0] SETTLE_MS_RST    = 16'd50;

endpackage

// ===== src/rlkd_channels.sv =====
// valid/ready channel interfaces for sample, key and register write items
interface rlkd_req_if;
   logic                                valid;
   logic                                ready;
   rlkd_pkg::opcode_type                opcode;
   logic [rlkd_pkg::SAMPLE_W-1:0]       adc_sample;
   logic [rlkd_pkg::STAMP_W-1:0]        now_ms;

   modport source (output valid, output opcode, output adc_sample, output now_ms,
                   input ready);
   modport sink   (input valid, input opcode, input adc_sample, input now_ms,
                   output ready);
endinterface

interface rlkd_rsp_if;
   logic                valid;
   logic                ready;
   rlkd_pkg::key_type   pressed_key;

   modport source (output valid, output pressed_key, input ready);
   modport sink   (input valid, input pressed_key, output ready);
endinterface

interface rlkd_csr_if;
   logic                              valid;
   logic                              ready;
   rlkd_pkg::csr_index_type           index;
   logic [rlkd_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/resistor_ladder_key_debouncer_core.sv =====
// resistor ladder keypad classifier and debouncer, top level
// an accepted sample item passes the input register, then the classify/debounce
//   logic into the result register, which presents its key item
// throughput: 1 item per cycle unless the key sink stalls; one state update per item
// reset: synchronous, active high; clears both keys, the change stamp, the pipeline
//   valids and loads the default thresholds and settle time
module resistor_ladder_key_debouncer_core (
   input  logic        clock,
   input  logic        reset,
   rlkd_req_if.sink    req_ch,
   rlkd_rsp_if.source  rsp_ch,
   rlkd_csr_if.sink    csr_ch
);
   import rlkd_pkg::*;

   // configuration registers
   logic [LIMIT_W-1:0]  right_limit_ff;
   logic [LIMIT_W-1:0]  up_limit_ff;
   logic [LIMIT_W-1:0]  down_limit_ff;
   logic [LIMIT_W-1:0]  left_limit_ff;
   logic [LIMIT_W-1:0]  select_limit_ff;
   logic [SETTLE_W-1:0] settle_ms_ff;

   // input register stage
   logic                s1_valid_ff;
   opcode_type          s1_opcode_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [STAMP_W-1:0]  s1_now_ff;

   // debounce state
   key_type             raw_key_ff,    raw_key_in;
   key_type             steady_key_ff, steady_key_in;
   logic [STAMP_W-1:0]  change_stamp_ff, change_stamp_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   key_type             pressed_key_ff, pressed_key_in;

   logic                s1_advance;
   logic [LIMIT_W-1:0]  level;
   key_type             level_key;
   logic                key_changed;
   logic [STAMP_W-1:0]  stamp_next;
   logic [STAMP_W-1:0]  elapsed;
   logic                settled;
   logic                promote;

   // register writes are always taken, unknown indexes are dropped
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         right_limit_ff  <= RIGHT_LIMIT_RST;
         up_limit_ff     <= UP_LIMIT_RST;
         down_limit_ff   <= DOWN_LIMIT_RST;
         left_limit_ff   <= LEFT_LIMIT_RST;
         select_limit_ff <= SELECT_LIMIT_RST;
         settle_ms_ff    <= SETTLE_MS_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_RIGHT_LIMIT:  right_limit_ff  <= csr_ch.data[LIMIT_W-1:0];
            CSR_UP_LIMIT:     up_limit_ff     <= csr_ch.data[LIMIT_W-1:0];
            CSR_DOWN_LIMIT:   down_limit_ff   <= csr_ch.data[LIMIT_W-1:0];
            CSR_LEFT_LIMIT:   left_limit_ff   <= csr_ch.data[LIMIT_W-1:0];
            CSR_SELECT_LIMIT: select_limit_ff <= csr_ch.data[LIMIT_W-1:0];
            CSR_SETTLE_MS:    settle_ms_ff    <= csr_ch.data[SETTLE_W-1:0];
            default: ;
         endcase
      end
   end

   // stage 1 moves on whenever the result register is empty or being drained
   assign s1_advance   = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         s1_opcode_ff <= req_ch.opcode;
         s1_sample_ff <= req_ch.adc_sample;
         s1_now_ff    <= req_ch.now_ms;
      end
   end

   // ladder thresholds, tested in fixed priority order; first hit wins
   assign level = {1'b0, s1_sample_ff};

   always_comb begin
      if (level < right_limit_ff) begin
         level_key = KEY_RIGHT;
      end else if (level < up_limit_ff) begin
         level_key = KEY_UP;
      end else if (level < down_limit_ff) begin
         level_key = KEY_DOWN;
      end else if (level < left_limit_ff) begin
         level_key = KEY_LEFT;
      end else if (level < select_limit_ff) begin
         level_key = KEY_SELECT;
      end else begin
         level_key = KEY_NONE;
      end
   end

   // a raw key change restarts the hold timer; elapsed wraps modulo 2^32
   assign key_changed = (level_key != raw_key_ff);
   assign stamp_next  = key_changed ? s1_now_ff : change_stamp_ff;
   assign elapsed     = s1_now_ff - stamp_next;
   assign settled     = (elapsed >= {{(STAMP_W-SETTLE_W){1'b0}}, settle_ms_ff});
   assign promote     = settled && (steady_key_ff != level_key);

   always_comb begin
      raw_key_in      = raw_key_ff;
      steady_key_in   = steady_key_ff;
      change_stamp_in = change_stamp_ff;
      pressed_key_in  = pressed_key_ff;
      if (s1_valid_ff && s1_advance) begin
         if (s1_opcode_ff == OP_CLEAR) begin
            raw_key_in      = KEY_NONE;
            steady_key_in   = KEY_NONE;
            change_stamp_in = s1_now_ff;
            pressed_key_in  = KEY_NONE;
         end else begin
            raw_key_in      = level_key;
            change_stamp_in = stamp_next;
            // a release that settles reports none, since level_key is then none
            pressed_key_in  = promote ? level_key : KEY_NONE;
            if (promote) begin
               steady_key_in = level_key;
            end
         end
      end
   end

   assign rsp_valid_in = s1_advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_key_ff      <= KEY_NONE;
         steady_key_ff   <= KEY_NONE;
         change_stamp_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         raw_key_ff      <= raw_key_in;
         steady_key_ff   <= steady_key_in;
         change_stamp_ff <= change_stamp_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pressed_key_ff <= pressed_key_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pressed_key = pressed_key_ff;

   // a reported press always matches the debounced key it came from
   a_press_is_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pressed_key_ff != KEY_NONE) |-> (pressed_key_ff == steady_key_ff))
      else $error("reported key differs from steady key");

   // a clear item leaves both keys at none
   a_clear_resets_keys: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_advance && s1_opcode_ff == OP_CLEAR)
         |=> (raw_key_ff == KEY_NONE && steady_key_ff == KEY_NONE))
      else $error("clear item did not reset key state");

   // an empty result register never holds off the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ch.ready)
      else $error("input stalled with empty result register");

   // debounce state moves only when an item leaves stage 1
   a_state_holds_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s1_advance) |=> ($stable(raw_key_ff) && $stable(steady_key_ff)
         && $stable(change_stamp_ff)))
      else $error("debounce state changed without an item");

endmodule

// ===== dv/resistor_ladder_key_debouncer_core_tb.sv =====
// self-checking testbench for the resistor ladder key debouncer core
`timescale 1ns / 1ps
module resistor_ladder_key_debouncer_core_tb;
   import rlkd_pkg::*;

   // register indexes past the last register, writes there must be dropped
   localparam csr_index_type CSR_SPARE_LO = 3'd6;
   localparam csr_index_type CSR_SPARE_HI = 3'd7;

   localparam int NUM_SETTINGS      = 12;
   localparam int ITEMS_PER_SETTING = 115;
   localparam int LEVEL_MAX         = (1 << SAMPLE_W) - 1;
   localparam int NUM_LIMITS        = 5;

   // one row of the directed sequence; want is only used when typed_in is set
   typedef struct {
      opcode_type          op;
      logic [SAMPLE_W-1:0] level;
      logic [STAMP_W-1:0]  now_ms;
      bit                  typed_in;
      key_type             want;
   } probe_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rlkd_req_if req_ch ();
   rlkd_rsp_if rsp_ch ();
   rlkd_csr_if csr_ch ();

   resistor_ladder_key_debouncer_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the thresholds and settle time, updated on every accepted write
   logic [LIMIT_W-1:0]  key_limit [0:NUM_LIMITS-1];
   logic [SETTLE_W-1:0] settle_time;

   // debounce state as the block should hold it
   key_type            track_raw;
   key_type            track_steady;
   logic [STAMP_W-1:0] track_stamp;

   // keys still owed by the block, oldest first
   key_type pending_presses [$];

   int mismatch_count = 0;
   int items_sent     = 0;
   int keys_reported  = 0;
   int src_idle_pct   = 0;
   int sink_stall_pct = 0;

   // hand-typed expectation that goes with the item currently on the bus
   bit                 typed_on;
   key_type            typed_key;
   logic [STAMP_W-1:0] now_cursor;

   // directed sequence at the reset thresholds (50/200/400/600/800) and 50 ms settle
   probe_row_type probe_table [0:24] = '{
      // after reset, no key and no time elapsed
      '{OP_POLL,  10'd1023, 32'd0,          1'b1, KEY_NONE},
      // right held 49 ms, then exactly the settle time
      '{OP_POLL,  10'd0,    32'd10,         1'b0, KEY_NONE},
      '{OP_POLL,  10'd0,    32'd59,         1'b1, KEY_NONE},
      '{OP_POLL,  10'd0,    32'd60,         1'b1, KEY_RIGHT},
      // still held, reported only once
      '{OP_POLL,  10'd0,    32'd500,        1'b1, KEY_NONE},
      // release settles, nothing reported
      '{OP_POLL,  10'd1023, 32'd510,        1'b0, KEY_NONE},
      '{OP_POLL,  10'd1023, 32'd560,        1'b1, KEY_NONE},
      // walk every threshold edge: last-below and first-at
      '{OP_POLL,  10'd49,   32'd600,        1'b0, KEY_NONE},
      '{OP_POLL,  10'd50,   32'd610,        1'b0, KEY_NONE},
      '{OP_POLL,  10'd199,  32'd660,        1'b1, KEY_UP},
      '{OP_POLL,  10'd399,  32'd700,        1'b0, KEY_NONE},
      '{OP_POLL,  10'd200,  32'd750,        1'b1, KEY_DOWN},
      '{OP_POLL,  10'd400,  32'd760,        1'b0, KEY_NONE},
      '{OP_POLL,  10'd599,  32'd810,        1'b1, KEY_LEFT},
      '{OP_POLL,  10'd600,  32'd820,        1'b0, KEY_NONE},
      '{OP_POLL,  10'd799,  32'd870,        1'b1, KEY_SELECT},
      '{OP_POLL,  10'd800,  32'd880,        1'b0, KEY_NONE},
      // clear always answers none
      '{OP_CLEAR, 10'd1023, 32'd900,        1'b1, KEY_NONE},
      // clear in the middle of a hold restarts the debounce
      '{OP_POLL,  10'd0,    32'd920,        1'b0, KEY_NONE},
      '{OP_CLEAR, 10'd0,    32'd949,        1'b1, KEY_NONE},
      '{OP_POLL,  10'd0,    32'd999,        1'b0, KEY_NONE},
      // hold across the 32-bit wrap of the millisecond counter
      '{OP_POLL,  10'd1023, 32'hFFFF_FFF0,  1'b0, KEY_NONE},
      '{OP_POLL,  10'd0,    32'hFFFF_FFF8,  1'b0, KEY_NONE},
      '{OP_POLL,  10'd0,    32'h0000_002A,  1'b1, KEY_RIGHT},
      '{OP_POLL,  10'd0,    32'hFFFF_FFFF,  1'b1, KEY_NONE}
   };

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("%0t mismatch: %s", $time, what);
   endtask

   // thresholds are tested in fixed order, first hit wins even when out of order
   function automatic key_type classify_level(logic [SAMPLE_W-1:0] level);
      for (int i = 0; i < NUM_LIMITS; i++)
         if ({1'b0, level} < key_limit[i]) return key_type'(i + 1);
      return KEY_NONE;
   endfunction

   // advance the debounce state by one item and return the key it reports
   function automatic key_type predict_press(opcode_type op, logic [SAMPLE_W-1:0] level,
                                             logic [STAMP_W-1:0] now_ms);
      key_type            hit;
      logic [STAMP_W-1:0] held;
      if (op == OP_CLEAR) begin
         track_raw    = KEY_NONE;
         track_steady = KEY_NONE;
         track_stamp  = now_ms;
         return KEY_NONE;
      end
      hit = classify_level(level);
      if (hit != track_raw) begin
         track_raw   = hit;
         track_stamp = now_ms;
      end
      // elapsed time wraps modulo 2^32
      held = now_ms - track_stamp;
      if (held >= {{(STAMP_W-SETTLE_W){1'b0}}, settle_time} && track_steady != track_raw) begin
         track_steady = track_raw;
         return track_raw;   // none on release
      end
      return KEY_NONE;
   endfunction

   function automatic void apply_csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx) inside
         CSR_RIGHT_LIMIT, CSR_UP_LIMIT, CSR_DOWN_LIMIT, CSR_LEFT_LIMIT,
         CSR_SELECT_LIMIT: key_limit[idx] = data[LIMIT_W-1:0];
         CSR_SETTLE_MS:    settle_time = data[SETTLE_W-1:0];
         default: ;        // unused index, dropped
      endcase
   endfunction

   // everything is observed in one place at the rising edge so ordering is fixed
   always @(posedge clock) begin : scoreboard
      key_type predicted;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_presses.size() == 0) begin
               report_mismatch($sformatf("key item %0d with no sample outstanding",
                                         rsp_ch.pressed_key));
            end else begin
               predicted = pending_presses.pop_front();
               if (rsp_ch.pressed_key !== predicted)
                  report_mismatch($sformatf("pressed_key %0d, predicted %0d",
                                            rsp_ch.pressed_key, predicted));
               else if (predicted != KEY_NONE)
                  keys_reported++;
            end
         end
         if (csr_ch.valid && csr_ch.ready)
            apply_csr_write(csr_ch.index, csr_ch.data);
         if (req_ch.valid && req_ch.ready) begin
            predicted = predict_press(req_ch.opcode, req_ch.adc_sample, req_ch.now_ms);
            pending_presses.push_back(typed_on ? typed_key : predicted);
         end
      end
   end

   // key sink, stalls at the rate of the current phase
   initial begin : key_sink
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance with valid
   // still high, so back-to-back items drop valid only for a drawn idle gap
   task automatic send_item(opcode_type op, logic [SAMPLE_W-1:0] level,
                            logic [STAMP_W-1:0] now_ms, bit typed_in, key_type want);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.opcode     = op;
      req_ch.adc_sample = level;
      req_ch.now_ms     = now_ms;
      typed_on          = typed_in;
      typed_key         = want;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // every item answers with one key item, so an empty queue means idle
   task automatic wait_drained();
      while (pending_presses.size() != 0) @(negedge clock);
   endtask

   // first few settings are the corners, the rest random
   task automatic program_setting(int which);
      logic [CSR_DATA_W-1:0] limits [0:NUM_LIMITS-1];
      logic [CSR_DATA_W-1:0] settle;
      int                    picks [$];
      case (which)
         0: begin   // every reading is no key, zero settle
            limits = '{default: '0};
            settle = '0;
         end
         1: begin   // limit past full scale catches every reading, longest settle
            limits = '{16'd1024, 16'd0, 16'd0, 16'd0, 16'd0};
            settle = '1;
         end
         2: begin   // thresholds out of order, zero settle
            limits = '{16'd300, 16'd100, 16'd2047, 16'd0, 16'd700};
            settle = '0;
         end
         3: begin
            limits = '{default: 16'd2047};
            settle = 16'd1;
         end
         default: begin
            if ($urandom_range(99) < 70) begin
               // ordered ladder, some limits past full scale
               repeat (NUM_LIMITS) picks.push_back($urandom_range(0, 1100));
               picks.sort();
               foreach (limits[i]) limits[i] = CSR_DATA_W'(picks[i]);
            end else begin
               // raw 16-bit data, upper bits must be dropped
               foreach (limits[i]) limits[i] = CSR_DATA_W'($urandom);
            end
            case ($urandom_range(0, 2))
               0:       settle = CSR_DATA_W'($urandom_range(0, 60));
               1:       settle = CSR_DATA_W'($urandom_range(0, 1000));
               default: settle = CSR_DATA_W'($urandom);
            endcase
         end
      endcase
      write_csr(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      write_csr(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      write_csr(CSR_RIGHT_LIMIT,  limits[0]);
      write_csr(CSR_UP_LIMIT,     limits[1]);
      write_csr(CSR_DOWN_LIMIT,   limits[2]);
      write_csr(CSR_LEFT_LIMIT,   limits[3]);
      write_csr(CSR_SELECT_LIMIT, limits[4]);
      write_csr(CSR_SETTLE_MS,    settle);
   endtask

   // readings on either side of a threshold are the interesting ones
   function automatic logic [SAMPLE_W-1:0] pick_level();
      int v;
      if ($urandom_range(99) < 40) begin
         v = int'(key_limit[3'($urandom_range(0, NUM_LIMITS - 1))])
             + int'($urandom_range(0, 2)) - 1;
         if (v < 0) v = 0;
         if (v > LEVEL_MAX) v = LEVEL_MAX;
         return v[SAMPLE_W-1:0];
      end
      return SAMPLE_W'($urandom_range(0, LEVEL_MAX));
   endfunction

   // mostly held keys with time steps scaled to the settle time, plus bounce and clears
   task automatic run_random(int count);
      int                  first;
      int                  pick;
      int                  span;
      logic [SAMPLE_W-1:0] level;
      first = items_sent;
      while (items_sent - first < count) begin
         pick = $urandom_range(99);
         span = int'(settle_time) / 2 + 3;
         // occasional jump anywhere in the millisecond range
         if ($urandom_range(99) < 2) now_cursor = $urandom;
         // hold off until every key item is back
         if ($urandom_range(199) == 0) begin
            req_ch.valid = 1'b0;
            wait_drained();
         end
         if (pick < 4) begin
            now_cursor += $urandom_range(0, span);
            send_item(OP_CLEAR, SAMPLE_W'($urandom), now_cursor, 1'b0, KEY_NONE);
         end else if (pick < 14) begin
            // single bounce sample
            now_cursor += $urandom_range(0, span);
            send_item(OP_POLL, SAMPLE_W'($urandom), now_cursor, 1'b0, KEY_NONE);
         end else begin
            level = pick_level();
            repeat ($urandom_range(1, 8)) begin
               now_cursor += $urandom_range(0, span);
               send_item(OP_POLL, level, now_cursor, 1'b0, KEY_NONE);
            end
         end
      end
   endtask

   initial begin : stimulus
      int mode;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = OP_POLL;
      req_ch.adc_sample = '0;
      req_ch.now_ms     = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = CSR_RIGHT_LIMIT;
      csr_ch.data       = '0;
      typed_on          = 1'b0;
      typed_key         = KEY_NONE;
      now_cursor        = '0;
      key_limit[0]      = RIGHT_LIMIT_RST;
      key_limit[1]      = UP_LIMIT_RST;
      key_limit[2]      = DOWN_LIMIT_RST;
      key_limit[3]      = LEFT_LIMIT_RST;
      key_limit[4]      = SELECT_LIMIT_RST;
      settle_time       = SETTLE_MS_RST;
      track_raw         = KEY_NONE;
      track_steady      = KEY_NONE;
      track_stamp       = '0;

      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed part at reset settings, no flow control pressure
      foreach (probe_table[i])
         send_item(probe_table[i].op, probe_table[i].level, probe_table[i].now_ms,
                   probe_table[i].typed_in, probe_table[i].want);
      req_ch.valid = 1'b0;
      wait_drained();

      // random part, flow-control mode rotates with each setting
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         mode = (s + 1) % 4;
         src_idle_pct   = (mode == 1) ? 73 : (mode == 3) ? 25 : 0;
         sink_stall_pct = (mode == 2) ? 73 : (mode == 3) ? 25 : 0;
         program_setting(s);
         run_random(ITEMS_PER_SETTING);
         req_ch.valid = 1'b0;
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (pending_presses.size() != 0)
         report_mismatch($sformatf("%0d key items never arrived", pending_presses.size()));

      $display("ran %0d poll/clear items over %0d threshold and settle settings, four flow modes",
               items_sent, NUM_SETTINGS + 1);
      $display("%0d debounced presses matched, %0d mismatches", keys_reported, mismatch_count);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #(5_000_000);
      $display("watchdog expired with %0d key items outstanding", pending_presses.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
src/rlkd_pkg.sv
src/rlkd_channels.sv
src/resistor_ladder_key_debouncer_core.sv
dv/resistor_ladder_key_debouncer_core_tb.sv
